>>> hw/rtl/rth_pkg.sv
// shared constants and types for the rgb to hsv converter
package rth_pkg;

  localparam int SAT_FRAC_BITS = 15;
  localparam int HUE_W         = 15;
  localparam int SAT_W         = 16;
  localparam int VAL_W         = 8;

  typedef logic [1:0] sector_t;

  localparam sector_t SEC_RED   = 2'd0;
  localparam sector_t SEC_GREEN = 2'd1;
  localparam sector_t SEC_BLUE  = 2'd2;

endpackage

>>> hw/rtl/rth_div.sv
// pipelined restoring divider, one quotient bit per register stage
module rth_div #(
  parameter int DEN_W = 8,
  parameter int QUO_W = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [DEN_W+QUO_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic [QUO_W-1:0]       quo
);

  localparam int ACC_W = DEN_W + QUO_W;

  // acc holds the partial remainder on top and the numerator bits still to
  // shift in below, with quotient bits filling from the bottom
  logic [ACC_W-1:0] acc [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];

  function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] a,
                                                 input logic [DEN_W-1:0] d);
    logic [ACC_W:0]   t;
    logic [DEN_W:0]   top;
    logic             q_bit;
    t     = {a, 1'b0};
    top   = t[ACC_W:QUO_W];
    q_bit = (top >= {1'b0, d});
    if (q_bit) begin
      top = top - {1'b0, d};
    end
    return {top[DEN_W-1:0], t[QUO_W-1:1], q_bit};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      acc[0]   <= div_step(num, den);
      den_q[0] <= den;
      for (int s = 1; s < QUO_W; s++) begin
        acc[s]   <= div_step(acc[s-1], den_q[s-1]);
        den_q[s] <= den_q[s-1];
      end
    end
  end

  assign quo = acc[QUO_W-1][QUO_W-1:0];

endmodule

>>> hw/rtl/rgb_to_hsv.sv
// rgb to hsv pixel converter, top level
//
// One pixel enters on red, green and blue with in_valid and in_ready; hue,
// saturation and brightness leave with out_valid and out_ready.
// Hue is in 2^-HUE_FRACTION_BITS degree units, saturation in Q1.15,
// brightness is the largest component.
// Pipeline at the default sizes, in order: input register,
// max/min/sector stage, numerator product stage, 16 divider stages (one
// quotient bit each, hue and saturation dividers side by side), and the
// output register with the sector offset. The divider quotient width sets
// the depth.
// Throughput is one pixel per cycle while out_ready stays high.
// When the receiver stalls with a result on the output, the whole pipeline
// holds and in_ready drops; nothing is lost or repeated. Bubbles let
// in_ready stay high while out_valid is low.
// Reset clears all valid bits; the pipeline comes up empty.
module rgb_to_hsv #(
  parameter int COMPONENT_BITS    = 8,
  parameter int HUE_FRACTION_BITS = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [COMPONENT_BITS-1:0]   red,
  input  logic [COMPONENT_BITS-1:0]   green,
  input  logic [COMPONENT_BITS-1:0]   blue,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rth_pkg::HUE_W-1:0]   hue,
  output logic [rth_pkg::SAT_W-1:0]   saturation,
  output logic [rth_pkg::VAL_W-1:0]   brightness
);
  import rth_pkg::*;

  localparam int C      = COMPONENT_BITS;
  localparam int DEG60  = 60 << HUE_FRACTION_BITS;
  localparam int DEG360 = 360 << HUE_FRACTION_BITS;
  localparam int QH     = $clog2(DEG60 + 1);
  localparam int QS     = SAT_FRAC_BITS + 1;
  localparam int Q      = (QH > QS) ? QH : QS;
  localparam int PW     = C + QH;
  localparam int NW     = C + Q;
  localparam int HW     = $clog2(DEG360 + 1);
  localparam int HX     = (HW > HUE_W) ? HW : HUE_W;
  localparam int SX     = (Q > SAT_W) ? Q : SAT_W;
  localparam int VX     = (C > VAL_W) ? C : VAL_W;
  localparam int L      = Q + 4;

  localparam logic [PW-1:0] DEG60_P  = PW'(DEG60);
  localparam logic [HW-1:0] DEG120_H = HW'(120 << HUE_FRACTION_BITS);
  localparam logic [HW-1:0] DEG240_H = HW'(240 << HUE_FRACTION_BITS);
  localparam logic [HW-1:0] DEG360_H = HW'(DEG360);

  logic       adv;
  logic [L-1:0] vld;

  assign adv       = ~vld[L-1] | out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  // input register
  logic [C-1:0] r_a, g_a, b_a;

  always_ff @(posedge clk) begin
    if (adv) begin
      r_a <= red;
      g_a <= green;
      b_a <= blue;
    end
  end

  // max, min, sector and signed difference
  logic [C-1:0] mx_c, mn_c, a_c, b_c;
  sector_t      sec_c;

  always_comb begin
    mx_c = r_a;
    mn_c = r_a;
    if (g_a > mx_c) mx_c = g_a;
    if (b_a > mx_c) mx_c = b_a;
    if (g_a < mn_c) mn_c = g_a;
    if (b_a < mn_c) mn_c = b_a;
    if (r_a == mx_c) begin
      sec_c = SEC_RED;
      a_c   = g_a;
      b_c   = b_a;
    end else if (g_a == mx_c) begin
      sec_c = SEC_GREEN;
      a_c   = b_a;
      b_c   = r_a;
    end else begin
      sec_c = SEC_BLUE;
      a_c   = r_a;
      b_c   = g_a;
    end
  end

  logic [C-1:0] mx_b, delta_b, diff_b;
  logic         neg_b;
  sector_t      sec_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      mx_b    <= mx_c;
      delta_b <= mx_c - mn_c;
      sec_b   <= sec_c;
      neg_b   <= (a_c < b_c);
      diff_b  <= (a_c >= b_c) ? (a_c - b_c) : (b_c - a_c);
    end
  end

  // numerators for both dividers, sideband starts its trip here
  logic [PW-1:0] prod;
  assign prod = PW'(diff_b) * DEG60_P;

  logic [NW-1:0] num_h, num_s;
  logic [C-1:0]  den_h, den_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      num_h <= NW'(prod);
      num_s <= NW'({delta_b, {SAT_FRAC_BITS{1'b0}}});
      den_h <= delta_b;
      den_s <= mx_b;
    end
  end

  sector_t      sec_d  [Q+1];
  logic         neg_d  [Q+1];
  logic         grey_d [Q+1];
  logic         blk_d  [Q+1];
  logic [C-1:0] mx_d   [Q+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sec_d[0]  <= sec_b;
      neg_d[0]  <= neg_b;
      grey_d[0] <= (delta_b == '0);
      blk_d[0]  <= (mx_b == '0);
      mx_d[0]   <= mx_b;
      for (int i = 1; i <= Q; i++) begin
        sec_d[i]  <= sec_d[i-1];
        neg_d[i]  <= neg_d[i-1];
        grey_d[i] <= grey_d[i-1];
        blk_d[i]  <= blk_d[i-1];
        mx_d[i]   <= mx_d[i-1];
      end
    end
  end

  logic [Q-1:0] quo_h, quo_s;

  rth_div #(.DEN_W(C), .QUO_W(Q)) u_div_hue (
    .clk (clk),
    .en  (adv),
    .num (num_h),
    .den (den_h),
    .quo (quo_h)
  );

  rth_div #(.DEN_W(C), .QUO_W(Q)) u_div_sat (
    .clk (clk),
    .en  (adv),
    .num (num_s),
    .den (den_s),
    .quo (quo_s)
  );

  // sector offset and sign, then output register
  logic [HW-1:0] mag, hue_c;
  logic [HX-1:0] hue_x;
  logic [SX-1:0] sat_x;
  logic [VX-1:0] val_x;

  assign mag = HW'(quo_h);

  always_comb begin
    hue_c = '0;
    if (!grey_d[Q]) begin
      case (sec_d[Q])
        SEC_RED: begin
          // a full turn wraps to zero
          if (neg_d[Q] && (mag != '0)) hue_c = DEG360_H - mag;
          else if (!neg_d[Q])           hue_c = mag;
        end
        SEC_GREEN: hue_c = neg_d[Q] ? (DEG120_H - mag) : (DEG120_H + mag);
        SEC_BLUE:  hue_c = neg_d[Q] ? (DEG240_H - mag) : (DEG240_H + mag);
        default:   hue_c = '0;
      endcase
    end
  end

  assign hue_x = HX'(hue_c);
  assign sat_x = blk_d[Q] ? '0 : SX'(quo_s);
  assign val_x = VX'(mx_d[Q]);

  always_ff @(posedge clk) begin
    if (adv) begin
      hue        <= hue_x[HUE_W-1:0];
      saturation <= sat_x[SAT_W-1:0];
      brightness <= val_x[VAL_W-1:0];
    end
  end

endmodule
